// ===== sv/top_k_sorted_score_table_macros.svh =====
// Assertion macros shared by the top-k sorted score table RTL.
// Every macro samples on clock and is switched off during reset.
`ifndef TOP_K_SORTED_SCORE_TABLE_MACROS_SVH
`define TOP_K_SORTED_SCORE_TABLE_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define TKST_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies a consequence on the next edge.
`define TKST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tkst_pkg.sv =====
// Shared types and constants of the top-k sorted score table.
// Used by the controller and the top level; depends on nothing.
package tkst_pkg;

   localparam int SCORE_W = 32;
   localparam int TAG_W   = 32;
   localparam int INDEX_W = 7;
   localparam int RANK_W  = 7;
   localparam int TOTAL_W = 8;
   localparam int ENTRY_W = SCORE_W + TAG_W;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } tkst_entry_type;

   typedef struct packed {
      logic                      accepted;
      logic [RANK_W-1:0]         rank;
      logic                      read_valid;
      logic signed [SCORE_W-1:0] read_score;
      logic [TAG_W-1:0]          read_tag;
      logic [TOTAL_W-1:0]        entry_total;
   } tkst_rsp_type;

endpackage

// ===== sv/tkst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the entries of the score table.
module tkst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tkst_ctrl.sv =====
// Sequencer of the score table: one shared score comparator walks the table
// from the bottom, moving entries down until the new entry finds its rank.
// Depends on tkst_pkg and the assertion macro header.
`include "top_k_sorted_score_table_macros.svh"

module tkst_ctrl #(
   parameter int DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_func,
   input  logic signed [tkst_pkg::SCORE_W-1:0] req_score,
   input  logic [tkst_pkg::TAG_W-1:0]          req_name_tag,
   input  logic [tkst_pkg::INDEX_W-1:0]        req_index,
   output logic                                busy,
   output logic                                res_valid,
   input  logic                                res_ready,
   output tkst_pkg::tkst_rsp_type              res,
   output logic                                wr_en,
   output logic [$clog2(DEPTH)-1:0]            wr_addr,
   output tkst_pkg::tkst_entry_type            wr_data,
   output logic [$clog2(DEPTH)-1:0]            rd_addr,
   input  tkst_pkg::tkst_entry_type            rd_data
);
   import tkst_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_CHECK = 6'b000100,
      S_SHIFT = 6'b001000,
      S_PLACE = 6'b010000,
      S_RESP  = 6'b100000
   } tkst_state_type;

   tkst_state_type            state_ff, state_in;
   logic [AW-1:0]             j_ff, j_in;
   logic [CW-1:0]             count_ff, count_in;
   logic signed [SCORE_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0]          tag_ff, tag_in;
   tkst_rsp_type              res_ff, res_in;
   logic                      full;
   logic                      index_hit;
   logic                      stored_ge;
   logic                      do_place;
   tkst_entry_type            new_entry;

   assign full      = (count_ff == CW'(DEPTH));
   assign index_hit = ({{CW{1'b0}}, req_index} < {7'b0, count_ff});
   assign stored_ge = (rd_data.score >= key_ff);
   assign new_entry = '{score: key_ff, tag: tag_ff};

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      count_in = count_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = j_ff;
      wr_data  = new_entry;
      rd_addr  = '0;
      do_place = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in             = req_score;
               tag_in             = req_name_tag;
               res_in             = '0;
               res_in.entry_total = TOTAL_W'(count_ff);
               if (req_func == FUNC_READ) begin
                  rd_addr = AW'(req_index);
                  if (index_hit) begin
                     res_in.read_valid = 1'b1;
                     state_in          = S_READ;
                  end else begin
                     state_in = S_RESP;
                  end
               end else if (full) begin
                  rd_addr  = AW'(DEPTH - 1);
                  j_in     = AW'(DEPTH - 1);
                  state_in = S_CHECK;
               end else if (count_ff == '0) begin
                  j_in     = '0;
                  state_in = S_PLACE;
               end else begin
                  j_in     = AW'(count_ff);
                  rd_addr  = AW'(count_ff - CW'(1));
                  state_in = S_SHIFT;
               end
            end
         end
         S_READ: begin
            res_in.read_score = rd_data.score;
            res_in.read_tag   = rd_data.tag;
            state_in          = S_RESP;
         end
         S_CHECK: begin
            if (stored_ge) begin
               state_in = S_RESP;
            end else begin
               rd_addr  = AW'(DEPTH - 2);
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (!stored_ge) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               j_in    = j_ff - AW'(1);
               rd_addr = j_ff - AW'(2);
               if (j_ff == AW'(1)) begin
                  state_in = S_PLACE;
               end
            end else begin
               do_place = 1'b1;
            end
         end
         S_PLACE: begin
            do_place = 1'b1;
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (do_place) begin
         wr_en              = 1'b1;
         wr_data            = new_entry;
         count_in           = full ? count_ff : count_ff + CW'(1);
         res_in.accepted    = 1'b1;
         res_in.rank        = RANK_W'(j_ff);
         res_in.entry_total = TOTAL_W'(count_in);
         state_in           = S_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      j_ff   <= j_in;
      key_ff <= key_in;
      tag_ff <= tag_in;
      res_ff <= res_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_RESP);
   assign res       = res_ff;

   `TKST_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "Entry count exceeds the table depth.")
   `TKST_ASSERT(a_write_in_range, !wr_en || (CW'(wr_addr) <= count_ff), "Write lands past the filled part of the table.")
   `TKST_ASSERT_NEXT(a_count_held, (state_ff != S_SHIFT) && (state_ff != S_PLACE), $stable(count_ff), "Entry count changed outside a placement.")

endmodule

// ===== sv/top_k_sorted_score_table.sv =====
// Top-k sorted score table: up to DEPTH (score, tag) entries held in descending order.
// A read beat passes through the read state to the result state, skipping the read when the index is
// out of range; an insert moves each lower entry down before it is placed, and a dropped one answers unaccepted.
// A new beat is accepted in the cycle after the previous result leaves the sequencer.
// Synchronous active-high reset empties the table; the entry RAM itself is not cleared.
// Depends on tkst_pkg, tkst_ram and tkst_ctrl.
module top_k_sorted_score_table #(
   parameter int DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic signed [tkst_pkg::SCORE_W-1:0] req_score,
   input  logic [tkst_pkg::TAG_W-1:0]          req_name_tag,
   input  logic [tkst_pkg::INDEX_W-1:0]        req_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic [tkst_pkg::RANK_W-1:0]         rsp_rank,
   output logic                                rsp_read_valid,
   output logic signed [tkst_pkg::SCORE_W-1:0] rsp_read_score,
   output logic [tkst_pkg::TAG_W-1:0]          rsp_read_tag,
   output logic [tkst_pkg::TOTAL_W-1:0]        rsp_entry_total
);
   import tkst_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic           busy;
   logic           res_valid;
   logic           res_ready;
   tkst_rsp_type   res;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   tkst_entry_type wr_data;
   logic [AW-1:0]  rd_addr;
   tkst_entry_type rd_data;
   logic           rsp_valid_ff, rsp_valid_in;
   tkst_rsp_type   rsp_ff;

   tkst_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   tkst_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_func    (req_func),
      .req_score   (req_score),
      .req_name_tag(req_name_tag),
      .req_index   (req_index),
      .busy        (busy),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   assign res_ready = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_ready) begin
         rsp_ff <= res;
      end
   end

   assign req_stall       = busy;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_ff.accepted;
   assign rsp_rank        = rsp_ff.rank;
   assign rsp_read_valid  = rsp_ff.read_valid;
   assign rsp_read_score  = rsp_ff.read_score;
   assign rsp_read_tag    = rsp_ff.read_tag;
   assign rsp_entry_total = rsp_ff.entry_total;

endmodule

// ===== test/top_k_sorted_score_table_tb.sv =====
// Self-checking testbench for the top-k sorted score table.
// It predicts each result beat from a queue model of the ranked entries and
// checks every field. Depends on tkst_pkg and top_k_sorted_score_table.
module top_k_sorted_score_table_tb;

   import tkst_pkg::*;

   localparam int TABLE_DEPTH = 128;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 150;
   localparam int PRESSURE_HOLD = 300;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_func = FUNC_INSERT;
   logic signed [SCORE_W-1:0] req_score = '0;
   logic [TAG_W-1:0]          req_name_tag = '0;
   logic [INDEX_W-1:0]        req_index = '0;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_accepted;
   logic [RANK_W-1:0]         rsp_rank;
   logic                      rsp_read_valid;
   logic signed [SCORE_W-1:0] rsp_read_score;
   logic [TAG_W-1:0]          rsp_read_tag;
   logic [TOTAL_W-1:0]        rsp_entry_total;

   logic signed [SCORE_W-1:0] ranked_score[$];
   logic [TAG_W-1:0]          ranked_tag[$];
   tkst_rsp_type              table_outcomes[$];
   tkst_rsp_type              oldest_outcome;

   bit idle_on = 1'b1;
   int stall_hold = 0;
   int stall_burst = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int insert_count = 0;
   int drop_count = 0;
   int read_count = 0;
   int invalid_read_count = 0;
   int peak_total = 0;

   top_k_sorted_score_table #(
      .DEPTH(TABLE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_score(req_score),
      .req_name_tag(req_name_tag),
      .req_index(req_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accepted(rsp_accepted),
      .rsp_rank(rsp_rank),
      .rsp_read_valid(rsp_read_valid),
      .rsp_read_score(rsp_read_score),
      .rsp_read_tag(rsp_read_tag),
      .rsp_entry_total(rsp_entry_total)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("top_k_sorted_score_table: mismatch");
         $finish;
      end
   end

   function automatic tkst_rsp_type predict_table_op(input logic func,
                                                     input logic signed [SCORE_W-1:0] score,
                                                     input logic [TAG_W-1:0] tag,
                                                     input logic [INDEX_W-1:0] index);
      tkst_rsp_type r;
      int pos;
      begin
         r = '0;
         if (func == FUNC_INSERT) begin
            insert_count++;
            pos = 0;
            while (pos < ranked_score.size() && ranked_score[pos] >= score) pos++;
            if (pos < TABLE_DEPTH) begin
               ranked_score.insert(pos, score);
               ranked_tag.insert(pos, tag);
               if (ranked_score.size() > TABLE_DEPTH) begin
                  void'(ranked_score.pop_back());
                  void'(ranked_tag.pop_back());
               end
               r.accepted = 1'b1;
               r.rank = pos[RANK_W-1:0];
            end else begin
               drop_count++;
            end
         end else begin
            read_count++;
            if (int'(index) < ranked_score.size()) begin
               r.read_valid = 1'b1;
               r.read_score = ranked_score[index];
               r.read_tag = ranked_tag[index];
            end else begin
               invalid_read_count++;
            end
         end
         r.entry_total = TOTAL_W'(ranked_score.size());
         if (ranked_score.size() > peak_total) peak_total = ranked_score.size();
         return r;
      end
   endfunction

   function automatic logic signed [SCORE_W-1:0] pick_score();
      int sel;
      int n;
      begin
         sel = $urandom_range(0, 9);
         n = ranked_score.size();
         case (sel)
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return int'($urandom_range(0, 8)) - 4;
            4, 5: begin
               if (n > 0) return ranked_score[$urandom_range(0, n - 1)];
               return $urandom;
            end
            6: begin
               if (n > 0) return ranked_score[n - 1];
               return $urandom;
            end
            default: return $urandom;
         endcase
      end
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      begin
         mismatches++;
         $display("cycle %0d: %s got %h want %h", cycle_count, field, got, want);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (table_outcomes.size() == 0) begin
            report_mismatch("result beat with none outstanding", 0, 0);
         end else begin
            oldest_outcome = table_outcomes.pop_front();
            if (rsp_accepted !== oldest_outcome.accepted)
               report_mismatch("accepted", 32'(rsp_accepted), 32'(oldest_outcome.accepted));
            if (rsp_rank !== oldest_outcome.rank)
               report_mismatch("rank", 32'(rsp_rank), 32'(oldest_outcome.rank));
            if (rsp_read_valid !== oldest_outcome.read_valid)
               report_mismatch("read_valid", 32'(rsp_read_valid),
                               32'(oldest_outcome.read_valid));
            if (rsp_read_score !== oldest_outcome.read_score)
               report_mismatch("read_score", rsp_read_score, oldest_outcome.read_score);
            if (rsp_read_tag !== oldest_outcome.read_tag)
               report_mismatch("read_tag", rsp_read_tag, oldest_outcome.read_tag);
            if (rsp_entry_total !== oldest_outcome.entry_total)
               report_mismatch("entry_total", 32'(rsp_entry_total),
                               32'(oldest_outcome.entry_total));
         end
      end
   end

   // The long hold takes priority over the short random bursts.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_hold > 0) begin
            rsp_stall = 1'b1;
            stall_hold--;
         end else if (stall_burst > 0) begin
            rsp_stall = 1'b1;
            stall_burst--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            stall_burst = $urandom_range(0, 3);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic send_beat(input logic func, input logic signed [SCORE_W-1:0] score,
                            input logic [TAG_W-1:0] tag, input logic [INDEX_W-1:0] index);
      int gap;
      begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid = 1'b1;
         req_func = func;
         req_score = score;
         req_name_tag = tag;
         req_index = index;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         table_outcomes.push_back(predict_table_op(func, score, tag, index));
      end
   endtask

   task automatic send_random_beat(input int insert_pct);
      logic [INDEX_W-1:0] index;
      begin
         if ($urandom_range(0, 99) < insert_pct) begin
            send_beat(FUNC_INSERT, pick_score(), $urandom, INDEX_W'($urandom));
         end else begin
            if ($urandom_range(0, 1) == 0)
               index = INDEX_W'($urandom_range(0, 127));
            else
               index = INDEX_W'(ranked_score.size() + $urandom_range(0, 2) - 1);
            send_beat(FUNC_READ, $urandom, $urandom, index);
         end
      end
   endtask

   task automatic test_empty_reads();
      begin
         send_beat(FUNC_READ, 32'sh7fffffff, 32'hffffffff, 7'd0);
         send_beat(FUNC_READ, 32'sh80000000, 32'h00000000, 7'd127);
      end
   endtask

   task automatic test_extremes_and_ties();
      int i;
      begin
         send_beat(FUNC_INSERT, 32'sh80000000, 32'h00000000, 7'd127);
         send_beat(FUNC_INSERT, 32'sh7fffffff, 32'hffffffff, 7'd0);
         send_beat(FUNC_INSERT, 32'sh00000000, 32'h5a5a5a5a, 7'd0);
         send_beat(FUNC_INSERT, -32'sd1, 32'ha5a5a5a5, 7'd0);
         send_beat(FUNC_INSERT, 32'sd7, 32'h0000000a, 7'd0);
         send_beat(FUNC_INSERT, 32'sd7, 32'h0000000b, 7'd0);
         send_beat(FUNC_INSERT, 32'sh80000000, 32'h00000001, 7'd0);
         for (i = 0; i < 9; i++)
            send_beat(FUNC_READ, 32'sd0, 32'd0, i[INDEX_W-1:0]);
         send_beat(FUNC_READ, 32'sd0, 32'd0, 7'd127);
      end
   endtask

   task automatic test_fill_up();
      begin
         while (ranked_score.size() < TABLE_DEPTH) send_random_beat(70);
      end
   endtask

   task automatic test_receiver_hold();
      int i;
      begin
         stall_hold = PRESSURE_HOLD;
         for (i = 0; i < 20; i++) send_random_beat(60);
      end
   endtask

   task automatic test_full_table();
      int i;
      begin
         for (i = 0; i < 1050; i++) send_random_beat(60);
      end
   endtask

   task automatic test_quiet_tail();
      int i;
      begin
         idle_on = 1'b0;
         for (i = 0; i < 120; i++) send_random_beat(50);
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;
      test_empty_reads();
      test_extremes_and_ties();
      test_fill_up();
      test_receiver_hold();
      test_full_table();
      test_quiet_tail();
      @(negedge clock);
      req_valid = 1'b0;
      while (table_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d inserts (%0d dropped on a full table) and %0d reads (%0d out of range)",
               insert_count, drop_count, read_count, invalid_read_count);
      $display("table reached %0d entries; receiver held off %0d cycles in one stretch",
               peak_total, PRESSURE_HOLD);
      if (mismatches == 0) begin
         $display("top_k_sorted_score_table: match");
      end else begin
         $display("top_k_sorted_score_table: mismatch");
      end
      $finish;
   end

endmodule
